>>> sv/fba_pkg.sv
// Package for the frame bitmap allocator: word types, request kinds, constants.
// No dependencies.
package fba_pkg;

	localparam int NUM_FRAMES_DEF  = 65536;
	localparam int FRAME_BYTES_DEF = 4096;
	localparam int WORD_BITS_DEF   = 64;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [2:0] {
		KIND_ALLOC   = 3'd0,
		KIND_FREE    = 3'd1,
		KIND_RESERVE = 3'd2,
		KIND_QUERY   = 3'd3,
		KIND_RELEASE = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FREE  = 2'd1,
		ST_RES_FAULT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_FRAME_LIMIT  = 2'd0,
		CFG_PROT_BASE    = 2'd1,
		CFG_PROT_COUNT   = 2'd2,
		CFG_LOW_RESERVED = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [47:0] phys_address;
		logic [19:0] frame_number;
		logic [20:0] frame_count;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [27:0] frame_address;
		logic        found;
		logic        is_used;
	} rsp_t;

	// Classified request handed from front to back. Frame numbers are 21 bits
	// so every 20-bit frame number and the limit fit; an address-derived frame keeps its low 21 bits.
	typedef struct packed {
		kind_t       kind;
		logic        bad_kind;
		logic        in_range;   // single-frame op target below limit
		logic [20:0] frame;      // single target, or first frame of region
		logic [20:0] last;       // region end (exclusive, clamped to limit)
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_EXEC,
		BK_WRITE,
		BK_OUT
	} bk_state_t;

endpackage

>>> sv/fba_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module fba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

>>> sv/fba_front.sv
// Front end: decodes requests, range checks, pushes commands into a small queue.
// Depends on fba_pkg.
module fba_front import fba_pkg::*; #(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        req,
	input  logic [20:0] lim,
	output logic        cmd_valid,
	input  logic        cmd_pop,
	output cmd_t        cmd
);
	localparam int SH = $clog2(FRAME_BYTES);

	cmd_t             q_q [QUEUE_DEPTH];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	cmd_t             nc;
	logic [47:0]      fa;
	logic [21:0]      endx;
	logic             push;

	assign in_ready  = (cnt_q != 2'(QUEUE_DEPTH));
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];
	assign push      = in_valid && in_ready;

	always_comb begin
		fa   = req.phys_address >> SH;
		endx = {2'b0, req.frame_number} + {1'b0, req.frame_count};
		nc          = '0;
		nc.kind     = kind_t'(req.kind);
		nc.bad_kind = (req.kind > 3'(KIND_RELEASE));
		if (req.kind == 3'(KIND_FREE)) begin
			nc.in_range = (fa < {27'd0, lim});
			nc.frame    = fa[20:0];
		end else begin
			nc.in_range = ({1'b0, req.frame_number} < lim);
			nc.frame    = {1'b0, req.frame_number};
		end
		nc.last = (endx > {1'b0, lim}) ? lim : endx[20:0];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= nc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (cmd_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule

>>> sv/fba_back.sv
// Back end: walks the bitmap RAM word by word to run each command.
// Depends on fba_pkg and fba_ram.
module fba_back import fba_pkg::*; #(
	parameter int NUM_FRAMES  = NUM_FRAMES_DEF,
	parameter int FRAME_BYTES = FRAME_BYTES_DEF,
	parameter int WORD_BITS   = WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_pop,
	input  cmd_t        cmd,
	input  logic [20:0] lim,
	input  logic [15:0] prot_base,
	input  logic [16:0] prot_count,
	input  logic [16:0] low_res,
	output logic        out_valid,
	input  logic        out_ready,
	output rsp_t        rsp
);
	localparam int WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BW    = $clog2(WORD_BITS);
	localparam int SH    = $clog2(FRAME_BYTES);

	bk_state_t          st_q, st_d;
	logic [AW:0]        clr_q;          // clearing pass counter
	logic               clr_done_q;
	logic [AW-1:0]      widx_q;
	logic [20:0]        f_q;            // current frame (word base for scans)
	cmd_t               c_q;
	rsp_t               rsp_q;
	logic               ov_q;
	logic [WORD_BITS-1:0] wr_q;
	logic               we;
	logic [AW-1:0]      ram_a;
	logic [WORD_BITS-1:0] rdata, newword;
	logic [WORD_BITS-1:0] freev;
	logic [BW-1:0]      hit;
	logic               any;
	logic [20:0]        wbase, fnext, phi;
	logic               done_word, fin;
	logic [27:0]        faddr;

	fba_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_ram (
		.clk(clk), .we(we), .addr(ram_a), .wdata(we && !clr_done_q ? '1 : wr_q),
		.rdata(rdata)
	);

	assign out_valid = ov_q;
	assign rsp       = rsp_q;
	assign phi       = {5'd0, prot_base} + {4'd0, prot_count};
	assign wbase     = {f_q[20:BW], BW'(0)};
	assign fnext     = wbase + 21'(WORD_BITS);

	// lowest free bit below limit in this word
	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			freev[i] = !rdata[i] && ((wbase + 21'(i)) < lim);
		end
		hit = '0;
		any = 1'b0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (freev[i]) begin
				hit = BW'(i);
				any = 1'b1;
			end
		end
	end

	// per-word update for allocate, free and reserve; release clears all eligible bits at once
	always_comb begin
		logic [20:0] fr;
		newword = rdata;
		faddr   = '0;
		fr      = '0;
		unique case (c_q.kind)
			KIND_ALLOC: begin
				if (any) newword[hit] = 1'b1;
				fr    = wbase + 21'(hit);
				faddr = 28'({fr, SH'(0)});
			end
			KIND_FREE: newword[c_q.frame[BW-1:0]] = 1'b0;
			KIND_RESERVE: newword[c_q.frame[BW-1:0]] = 1'b1;
			KIND_RELEASE: begin
				for (int i = 0; i < WORD_BITS; i++) begin
					fr = wbase + 21'(i);
					if (fr >= c_q.frame && fr < c_q.last &&
					    !(fr >= {5'd0, prot_base} && fr < phi) &&
					    fr >= {4'd0, low_res}) begin
						newword[i] = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	assign done_word = (fnext >= ((c_q.kind == KIND_ALLOC) ? lim : c_q.last));
	assign ram_a = !clr_done_q ? clr_q[AW-1:0] : widx_q;

	always_comb begin
		st_d    = st_q;
		cmd_pop = 1'b0;
		we      = !clr_done_q;
		fin     = 1'b0;
		unique case (st_q)
			BK_IDLE: if (clr_done_q && cmd_valid && !ov_q) begin
				cmd_pop = 1'b1;
				st_d    = BK_READ;
			end
			BK_READ: st_d = BK_EXEC;
			BK_EXEC: begin
				priority if (c_q.bad_kind || c_q.kind == KIND_QUERY) begin
					fin = 1'b1;
				end else if (c_q.kind == KIND_ALLOC) begin
					if (any) st_d = BK_WRITE;
					else if (done_word) fin = 1'b1;
					else st_d = BK_READ;
				end else if (c_q.kind == KIND_RELEASE) begin
					st_d = BK_WRITE;
				end else begin
					if (c_q.in_range) st_d = BK_WRITE;
					else fin = 1'b1;
				end
				if (fin) st_d = BK_OUT;
			end
			BK_WRITE: begin
				we = 1'b1;
				if (c_q.kind == KIND_RELEASE && !done_word) st_d = BK_READ;
				else st_d = BK_OUT;
			end
			BK_OUT: st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		// load only on a pop so a waiting result word stays put
		if (cmd_pop) begin
			c_q    <= cmd;
			f_q    <= (cmd.kind == KIND_ALLOC) ? 21'd0 : cmd.frame;
			widx_q <= AW'((cmd.kind == KIND_ALLOC ? 21'd0 : cmd.frame) >> BW);
			rsp_q  <= '0;
		end
		if (st_q == BK_EXEC) begin
			wr_q <= newword;
			if (c_q.kind == KIND_QUERY) rsp_q.is_used <= c_q.in_range && rdata[c_q.frame[BW-1:0]];
			if (c_q.kind == KIND_RESERVE && !c_q.in_range) rsp_q.status <= ST_RES_FAULT;
			if (c_q.kind == KIND_ALLOC) begin
				if (any) begin
					rsp_q.found         <= 1'b1;
					rsp_q.frame_address <= faddr;
				end else if (done_word) begin
					rsp_q.status <= ST_NO_FREE;
				end else begin
					f_q    <= fnext;
					widx_q <= widx_q + 1'b1;
				end
			end
		end
		if (st_q == BK_WRITE && c_q.kind == KIND_RELEASE && !done_word) begin
			f_q    <= fnext;
			widx_q <= widx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= BK_IDLE;
			clr_q      <= '0;
			clr_done_q <= 1'b0;
			ov_q       <= 1'b0;
		end else begin
			st_q <= st_d;
			if (!clr_done_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == (AW+1)'(WORDS - 1)) clr_done_q <= 1'b1;
			end
			if (st_q == BK_OUT) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end
endmodule

>>> sv/frame_bitmap_allocator.sv
// Frame bitmap allocator: one used bit per frame in a WORD_BITS-wide RAM.
// Each accepted item waits in a two-entry queue; the back end then reads a RAM
// word, checks it, writes it back and presents the result. Query, unused kinds,
// out-of-range targets and an allocate that finds nothing skip the write. Allocate
// reads words in turn until a free bit or the limit; release reads, updates and
// writes back every word spanned. The next item starts only once the result is
// taken (single RAM port). Reset: async, active low; a clearing pass writes ones
// (all used) to every RAM word before the first item is worked.
// Config registers return to 65536 / 0 / 0 / 256.
module frame_bitmap_allocator import fba_pkg::*; #(
	parameter int NUM_FRAMES  = NUM_FRAMES_DEF,
	parameter int FRAME_BYTES = FRAME_BYTES_DEF,
	parameter int WORD_BITS   = WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        in_word,
	output logic        out_valid,
	input  logic        out_ready,
	output rsp_t        out_word,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	logic [16:0] frame_limit_q, prot_count_q, low_res_q;
	logic [15:0] prot_base_q;
	logic [20:0] lim;
	logic        cmd_valid, cmd_pop;
	cmd_t        cmd;

	// effective limit = min(frame_limit, NUM_FRAMES)
	assign lim = ({4'd0, frame_limit_q} < 21'(NUM_FRAMES)) ? {4'd0, frame_limit_q}
	                                                       : 21'(NUM_FRAMES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= 17'd65536;
			prot_base_q   <= '0;
			prot_count_q  <= '0;
			low_res_q     <= 17'd256;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FRAME_LIMIT:  frame_limit_q <= cfg_data;
				CFG_PROT_BASE:    prot_base_q   <= cfg_data[15:0];
				CFG_PROT_COUNT:   prot_count_q  <= cfg_data;
				CFG_LOW_RESERVED: low_res_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	fba_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.req(in_word), .lim(lim), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd)
	);

	fba_back #(.NUM_FRAMES(NUM_FRAMES), .FRAME_BYTES(FRAME_BYTES),
	           .WORD_BITS(WORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd),
		.lim(lim), .prot_base(prot_base_q), .prot_count(prot_count_q),
		.low_res(low_res_q), .out_valid(out_valid), .out_ready(out_ready), .rsp(out_word)
	);
endmodule

>>> tb/tb.sv
// Self-checking bench for frame_bitmap_allocator: random and directed requests,
// responses checked against an in-bench bitmap predictor. Depends on fba_pkg and frame_bitmap_allocator.
module tb;
	import fba_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NFR = NUM_FRAMES_DEF;
	localparam int FBYTES = FRAME_BYTES_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_word;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [16:0] cfg_data = '0;

	frame_bitmap_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state: one bit per frame, 1 = used
	bit frame_used [NFR];
	int unsigned lim_reg, prot_base, prot_cnt, low_rsvd;

	req_t pending_words[$];   // filled by stimulus, drained by driver
	rsp_t expected_rsp[$];    // predicted responses, oldest first
	int errors = 0;
	longint cycles = 0;
	bit calm = 1'b0;          // no idling in the last part
	int hold_off = 0;         // receiver long stall request, in cycles

	function automatic rsp_t predict(req_t w);
		rsp_t r;
		int unsigned lim, f, fin;
		longint unsigned a;
		r = '0;
		lim = (lim_reg < NFR) ? lim_reg : NFR;
		case (w.kind)
			KIND_ALLOC: begin
				r.status = ST_NO_FREE;
				for (f = 0; f < lim; f++)
					if (!frame_used[f]) begin
						frame_used[f] = 1'b1;
						r.status = ST_OK;
						r.found = 1'b1;
						a = longint'(f) * FBYTES;
						r.frame_address = a[27:0];
						break;
					end
			end
			KIND_FREE: begin
				a = w.phys_address / FBYTES;
				if (a < lim) frame_used[a] = 1'b0;
			end
			KIND_RESERVE: begin
				if (w.frame_number < lim) frame_used[w.frame_number] = 1'b1;
				else r.status = ST_RES_FAULT;
			end
			KIND_QUERY:
				r.is_used = (w.frame_number < lim) && frame_used[w.frame_number];
			KIND_RELEASE: begin
				fin = w.frame_number + w.frame_count;
				if (fin > lim) fin = lim;
				for (f = w.frame_number; f < fin; f++) begin
					if (f >= prot_base && f < prot_base + prot_cnt) continue;
					if (f < low_rsvd) continue;
					frame_used[f] = 1'b0;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// driver: hold word until accepted, random idle bursts
	int send_gap = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				in_word <= pending_words[0];
				expected_rsp.push_back(predict(pending_words.pop_front()));
				in_valid <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 8);
			end else
				in_valid <= 1'b0;
		end
	end

	// monitor: check accepted responses, drive ready with stalls
	int recv_gap = 0;
	always @(posedge clk) begin
		rsp_t e;
		if (out_valid && out_ready) begin
			if (expected_rsp.size() == 0) begin
				$error("unexpected response %h", out_word);
				errors++;
			end else begin
				e = expected_rsp.pop_front();
				if (out_word.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, out_word.status); errors++;
				end
				if (out_word.frame_address !== e.frame_address) begin
					$error("frame_address exp %h got %h", e.frame_address,
						out_word.frame_address); errors++;
				end
				if (out_word.found !== e.found) begin
					$error("found exp %0d got %0d", e.found, out_word.found); errors++;
				end
				if (out_word.is_used !== e.is_used) begin
					$error("is_used exp %0d got %0d", e.is_used, out_word.is_used); errors++;
				end
			end
		end
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 8);
		end
	end

	always @(posedge clk)
		if (cycles > 10000000) begin
			$display("tb: done, errors");
			$finish;
		end

	function automatic req_t mk(kind_t k, int unsigned fn, int unsigned cnt);
		req_t w;
		w = '0;
		w.kind = k;
		w.frame_number = fn[19:0];
		w.frame_count = cnt[20:0];
		w.phys_address = 48'({$urandom(), $urandom()});
		return w;
	endfunction

	function automatic req_t free_at(int unsigned f);
		req_t w;
		w = mk(KIND_FREE, $urandom(), $urandom());
		w.phys_address = 48'(longint'(f) * FBYTES + $urandom_range(0, FBYTES - 1));
		return w;
	endfunction

	task automatic drain();
		wait (pending_words.size() == 0 && !in_valid && expected_rsp.size() == 0);
		repeat (2 * NFR / WORD_BITS_DEF + 200) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int unsigned v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[16:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FRAME_LIMIT: lim_reg = v & 17'h1FFFF;
			CFG_PROT_BASE: prot_base = v & 16'hFFFF;
			CFG_PROT_COUNT: prot_cnt = v & 17'h1FFFF;
			default: low_rsvd = v & 17'h1FFFF;
		endcase
	endtask

	// one random item of a chosen phase, focused on a small frame window
	function automatic req_t rand_item(int unsigned span);
		int unsigned f;
		req_t w;
		f = $urandom_range(0, span);
		case ($urandom_range(0, 9))
			0, 1, 2: w = mk(KIND_ALLOC, $urandom(), $urandom());
			3, 4: w = free_at(f);
			5: w = mk(KIND_RESERVE, ($urandom_range(0, 7) == 0) ? $urandom() : f, 0);
			6, 7: w = mk(KIND_QUERY, ($urandom_range(0, 7) == 0) ? $urandom() : f, 0);
			8: w = mk(KIND_RELEASE, f, $urandom_range(0, 40));
			default: begin
				w = '0;
				w.phys_address = 48'({$urandom(), $urandom()});
				w.frame_number = 20'($urandom());
				w.frame_count = 21'($urandom());
				w.kind = 3'($urandom_range(0, 7));
				if ($urandom_range(0, 3) == 0) w = free_at($urandom_range(0, NFR + 100));
			end
		endcase
		return w;
	endfunction

	initial begin
		for (int i = 0; i < NFR; i++) frame_used[i] = 1'b1;
		lim_reg = 65536; prot_base = 0; prot_cnt = 0; low_rsvd = 256;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: full map, extremes, each kind, unused kinds
		pending_words.push_back(mk(KIND_ALLOC, 0, 0));           // nothing free
		pending_words.push_back(mk(KIND_QUERY, 0, 0));
		pending_words.push_back(mk(KIND_QUERY, 20'hFFFFF, 0));    // past limit
		pending_words.push_back(mk(KIND_RESERVE, 20'hFFFFF, 0));  // fault
		pending_words.push_back(mk(KIND_RELEASE, 0, 300));        // low reserved spared
		pending_words.push_back(mk(KIND_RELEASE, 500, 0));        // empty region
		pending_words.push_back(mk(KIND_ALLOC, 0, 0));
		pending_words.push_back(mk(KIND_ALLOC, 0, 0));
		pending_words.push_back(free_at(65535));
		pending_words.push_back(mk(KIND_QUERY, 65535, 0));
		pending_words.push_back(free_at(1 << 20));               // ignored
		begin
			req_t w;
			w = mk(KIND_FREE, 0, 0);
			w.phys_address = '1;
			pending_words.push_back(w);
			w = mk(KIND_RELEASE, 20'hFFFFF, 21'h1FFFFF);
			pending_words.push_back(w);
			for (int k = 5; k < 8; k++) begin
				w = '1;
				w.kind = 3'(k);
				pending_words.push_back(w);
			end
		end
		pending_words.push_back(mk(KIND_RESERVE, 300, 0));
		pending_words.push_back(mk(KIND_QUERY, 300, 0));
		drain();

		// configuration phases; extremes included
		for (int ph = 0; ph < 6; ph++) begin
			int unsigned span;
			case (ph)
				0: begin write_reg(CFG_FRAME_LIMIT, 65536); write_reg(CFG_PROT_BASE, 280);
					write_reg(CFG_PROT_COUNT, 20); write_reg(CFG_LOW_RESERVED, 0); end
				1: begin write_reg(CFG_FRAME_LIMIT, 0); write_reg(CFG_LOW_RESERVED, 65536); end
				2: begin write_reg(CFG_FRAME_LIMIT, 200); write_reg(CFG_PROT_BASE, 65535);
					write_reg(CFG_PROT_COUNT, 65536); write_reg(CFG_LOW_RESERVED, 0); end
				3: begin write_reg(CFG_FRAME_LIMIT, 131071); write_reg(CFG_PROT_BASE, 0);
					write_reg(CFG_PROT_COUNT, 0); write_reg(CFG_LOW_RESERVED, 17); end
				4: begin write_reg(CFG_FRAME_LIMIT, 100); write_reg(CFG_PROT_BASE, 30);
					write_reg(CFG_PROT_COUNT, 10); end
				default: begin write_reg(CFG_FRAME_LIMIT, 65536);
					write_reg(CFG_LOW_RESERVED, 256); calm = 1'b1; end
			endcase
			span = (ph == 3 || ph == 5) ? 400 : 260;
			// open up some frames so allocation finds something
			pending_words.push_back(mk(KIND_RELEASE, 0, 450));
			if (ph == 2) hold_off = 300;   // long receiver stall, sender keeps going
			for (int i = 0; i < 65; i++) pending_words.push_back(rand_item(span));
			drain();
		end

		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule

>>> sim.f
sv/fba_pkg.sv
sv/fba_ram.sv
sv/fba_front.sv
sv/fba_back.sv
sv/frame_bitmap_allocator.sv
tb/tb.sv
